// File: hdl/cmd_pkg.sv
// Shared types and constants for the chunked message deframer.
`default_nettype none

package cmd_pkg;

    // Register widths
    localparam int LEN_W   = 17;
    localparam int IDLE_W  = 4;
    localparam int BYTE_W  = 8;
    localparam int CFG_W   = 17;
    localparam int CFG_IDX_W = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_IDLE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CSUM_BASE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CSUM_BYP  = 2'd3;

    // Register reset values
    localparam logic [LEN_W-1:0]  RST_MAX_LEN   = 17'd65536;
    localparam logic [IDLE_W-1:0] RST_MAX_IDLE  = 4'd8;
    localparam logic [BYTE_W-1:0] RST_CSUM_BASE = 8'hAA;
    localparam logic [BYTE_W-1:0] RST_CSUM_BYP  = 8'h88;

    // Header layout
    localparam logic [LEN_W-1:0] HDR_BYTES = 17'd3;
    localparam logic [LEN_W-1:0] MIN_TOTAL = 17'd4;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_BODY   = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        ST_BUSY   = 3'd0,
        ST_GOOD   = 3'd1,
        ST_SHORT  = 3'd2,
        ST_SIZE   = 3'd3,
        ST_CONT   = 3'd4,
        ST_NOPROG = 3'd5,
        ST_CSUM   = 3'd6
    } t_status;

endpackage : cmd_pkg

`default_nettype wire

// File: hdl/chunked_message_deframer_unit.sv
// Chunked message deframer: header/continuation checks and checksum.
// A result word is registered; it appears in the cycle after its input is accepted.
// Throughput: one input word per cycle unless the result side stalls; the framing
// state updates through compare-and-add logic; a result register decouples the sides.
// Reset (i_rst_n low, synchronous): idle, all counters cleared, registers to
// their defaults (max length 65536, 8 idle chunks, base 0xAA, bypass 0x88).
`default_nettype none

module chunked_message_deframer_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic                        i_cfg_we,
    input  wire logic [cmd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [cmd_pkg::CFG_W-1:0]   i_cfg_wdata,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  wire logic [1:0]  s_axis_tuser,   // [0] operation, [1] chunk_start
    input  wire logic        s_axis_tlast,   // chunk_end
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] msg_byte
    output logic [3:0]       m_axis_tuser,   // [0] msg_byte_valid, [3:1] status
    output logic             m_axis_tlast    // msg_last
);

    // configuration registers
    logic [cmd_pkg::LEN_W-1:0]  r_max_len;
    logic [cmd_pkg::IDLE_W-1:0] r_max_idle;
    logic [cmd_pkg::BYTE_W-1:0] r_csum_base;
    logic [cmd_pkg::BYTE_W-1:0] r_csum_byp;

    // framing state
    cmd_pkg::t_phase            r_phase,      n_phase;
    logic [1:0]                 r_hdr_idx,    n_hdr_idx;
    logic [7:0]                 r_command,    n_command;
    logic [cmd_pkg::LEN_W-1:0]  r_exp_total,  n_exp_total;
    logic [cmd_pkg::LEN_W-1:0]  r_rx_count,   n_rx_count;
    logic [7:0]                 r_byte_sum,   n_byte_sum;
    logic [cmd_pkg::IDLE_W-1:0] r_idle_cnt,   n_idle_cnt;
    logic                       r_discard,    n_discard;
    logic                       r_in_chunk,   n_in_chunk;

    // result register
    logic                       r_out_valid;
    logic [7:0]                 r_msg_byte,   n_msg_byte;
    logic                       r_msg_valid,  n_msg_valid;
    logic                       r_msg_last,   n_msg_last;
    cmd_pkg::t_status           r_status,     n_status;

    // shared decode of the incoming word
    logic                       accept_in;
    logic                       op_empty;
    logic [7:0]                 rx_byte;
    logic                       chunk_end;
    logic                       first_byte;
    logic [cmd_pkg::IDLE_W:0]   idle_next;
    logic                       idle_over;
    logic [cmd_pkg::LEN_W-1:0]  total;
    logic                       size_bad;
    logic                       cont_bad;
    logic [cmd_pkg::LEN_W-1:0]  rx_count_inc;
    logic                       msg_done;
    logic [7:0]                 csum_want;
    logic                       csum_ok;
    logic                       go_idle;
    logic                       drop_rest;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept_in     = s_axis_tvalid && s_axis_tready;

    assign op_empty   = s_axis_tuser[0];
    assign rx_byte    = s_axis_tdata;
    assign chunk_end  = s_axis_tlast;
    assign first_byte = !r_in_chunk;

    // idle chunk counter check
    assign idle_next = {1'b0, r_idle_cnt} + {{cmd_pkg::IDLE_W{1'b0}}, 1'b1};
    assign idle_over = idle_next > {1'b0, r_max_idle};

    // total length from the low length byte held in r_exp_total and the high byte
    assign total    = cmd_pkg::HDR_BYTES + r_exp_total + {1'b0, rx_byte, 8'h00};
    assign size_bad = (total < cmd_pkg::MIN_TOTAL) || (total > r_max_len);

    // continuation byte must be the command with bit 0 set
    assign cont_bad = !rx_byte[0] || ({rx_byte[7:1], 1'b0} != r_command);

    // body progress and checksum
    assign rx_count_inc = r_rx_count + {{(cmd_pkg::LEN_W-1){1'b0}}, 1'b1};
    assign msg_done     = rx_count_inc >= r_exp_total;
    assign csum_want    = r_csum_base - r_byte_sum;
    assign csum_ok      = (rx_byte == r_csum_byp) || (rx_byte == csum_want);

    // next framing state
    always_comb begin
        n_phase     = r_phase;
        n_hdr_idx   = r_hdr_idx;
        n_command   = r_command;
        n_exp_total = r_exp_total;
        n_rx_count  = r_rx_count;
        n_byte_sum  = r_byte_sum;
        n_idle_cnt  = r_idle_cnt;
        n_discard   = r_discard;
        n_in_chunk  = r_in_chunk;
        go_idle     = 1'b0;
        drop_rest   = 1'b0;

        if (op_empty) begin
            if (idle_over) begin
                go_idle   = 1'b1;
                drop_rest = r_in_chunk || r_discard;
            end else begin
                n_idle_cnt = idle_next[cmd_pkg::IDLE_W-1:0];
            end
        end else begin
            n_in_chunk = !chunk_end;
            if (r_discard) begin
                if (chunk_end) begin
                    n_discard = 1'b0;
                end
            end else begin
                case (r_phase)
                    cmd_pkg::PH_IDLE: begin
                        n_command  = rx_byte;
                        n_byte_sum = rx_byte;
                        n_rx_count = 17'd1;
                        n_hdr_idx  = 2'd1;
                        n_idle_cnt = '0;
                        n_phase    = cmd_pkg::PH_HEADER;
                        go_idle    = chunk_end;
                    end
                    cmd_pkg::PH_HEADER: begin
                        if (r_hdr_idx == 2'd1) begin
                            n_exp_total = {9'd0, rx_byte};
                            n_byte_sum  = r_byte_sum + rx_byte;
                            n_rx_count  = 17'd2;
                            n_hdr_idx   = 2'd2;
                            go_idle     = chunk_end;
                        end else if (size_bad) begin
                            go_idle   = 1'b1;
                            drop_rest = !chunk_end;
                        end else begin
                            n_exp_total = total;
                            n_byte_sum  = r_byte_sum + rx_byte;
                            n_rx_count  = 17'd3;
                            n_hdr_idx   = 2'd3;
                            n_phase     = cmd_pkg::PH_BODY;
                        end
                    end
                    cmd_pkg::PH_BODY: begin
                        if (first_byte) begin
                            if (cont_bad) begin
                                go_idle   = 1'b1;
                                drop_rest = !chunk_end;
                            end else if (chunk_end) begin
                                if (idle_over) begin
                                    go_idle = 1'b1;
                                end else begin
                                    n_idle_cnt = idle_next[cmd_pkg::IDLE_W-1:0];
                                end
                            end
                        end else begin
                            n_rx_count = rx_count_inc;
                            n_idle_cnt = '0;
                            if (msg_done) begin
                                go_idle   = 1'b1;
                                drop_rest = !chunk_end;
                            end else begin
                                n_byte_sum = r_byte_sum + rx_byte;
                            end
                        end
                    end
                    default: begin
                        go_idle = 1'b1;
                    end
                endcase
            end
        end

        // completion or error: back to idle
        if (go_idle) begin
            n_phase     = cmd_pkg::PH_IDLE;
            n_hdr_idx   = '0;
            n_command   = '0;
            n_exp_total = '0;
            n_rx_count  = '0;
            n_byte_sum  = '0;
            n_idle_cnt  = '0;
            n_discard   = drop_rest;
        end
    end

    // result word for the incoming word
    always_comb begin
        n_msg_valid = 1'b0;
        n_msg_last  = 1'b0;
        n_status    = cmd_pkg::ST_BUSY;

        if (op_empty) begin
            if (idle_over) begin
                n_status = cmd_pkg::ST_NOPROG;
            end
        end else if (!r_discard) begin
            case (r_phase)
                cmd_pkg::PH_IDLE: begin
                    if (chunk_end) n_status = cmd_pkg::ST_SHORT;
                    else           n_msg_valid = 1'b1;
                end
                cmd_pkg::PH_HEADER: begin
                    if (r_hdr_idx == 2'd1) begin
                        if (chunk_end) n_status = cmd_pkg::ST_SHORT;
                        else           n_msg_valid = 1'b1;
                    end else if (size_bad) begin
                        n_status = cmd_pkg::ST_SIZE;
                    end else begin
                        n_msg_valid = 1'b1;
                    end
                end
                cmd_pkg::PH_BODY: begin
                    if (first_byte) begin
                        if (cont_bad) begin
                            n_status = cmd_pkg::ST_CONT;
                        end else if (chunk_end && idle_over) begin
                            n_status = cmd_pkg::ST_NOPROG;
                        end
                    end else begin
                        n_msg_valid = 1'b1;
                        if (msg_done) begin
                            n_msg_last = 1'b1;
                            n_status   = csum_ok ? cmd_pkg::ST_GOOD : cmd_pkg::ST_CSUM;
                        end
                    end
                end
                default: begin
                    n_status = cmd_pkg::ST_BUSY;
                end
            endcase
        end

        n_msg_byte = n_msg_valid ? rx_byte : 8'h00;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len   <= cmd_pkg::RST_MAX_LEN;
            r_max_idle  <= cmd_pkg::RST_MAX_IDLE;
            r_csum_base <= cmd_pkg::RST_CSUM_BASE;
            r_csum_byp  <= cmd_pkg::RST_CSUM_BYP;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cmd_pkg::CFG_MAX_LEN:   r_max_len   <= i_cfg_wdata;
                cmd_pkg::CFG_MAX_IDLE:  r_max_idle  <= i_cfg_wdata[cmd_pkg::IDLE_W-1:0];
                cmd_pkg::CFG_CSUM_BASE: r_csum_base <= i_cfg_wdata[cmd_pkg::BYTE_W-1:0];
                cmd_pkg::CFG_CSUM_BYP:  r_csum_byp  <= i_cfg_wdata[cmd_pkg::BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // framing state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= cmd_pkg::PH_IDLE;
            r_hdr_idx   <= '0;
            r_command   <= '0;
            r_exp_total <= '0;
            r_rx_count  <= '0;
            r_byte_sum  <= '0;
            r_idle_cnt  <= '0;
            r_discard   <= 1'b0;
            r_in_chunk  <= 1'b0;
        end else if (accept_in) begin
            r_phase     <= n_phase;
            r_hdr_idx   <= n_hdr_idx;
            r_command   <= n_command;
            r_exp_total <= n_exp_total;
            r_rx_count  <= n_rx_count;
            r_byte_sum  <= n_byte_sum;
            r_idle_cnt  <= n_idle_cnt;
            r_discard   <= n_discard;
            r_in_chunk  <= n_in_chunk;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept_in) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_msg_byte  <= n_msg_byte;
            r_msg_valid <= n_msg_valid;
            r_msg_last  <= n_msg_last;
            r_status    <= n_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_msg_byte;
    assign m_axis_tuser  = {r_status, r_msg_valid};
    assign m_axis_tlast  = r_msg_last;

`ifndef SYNTH
    // a message end word always carries a message byte
    a_last_has_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_msg_last |-> r_msg_valid)
        else $error("message end without a message byte");

    // framing errors never carry a message byte
    a_err_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_status == cmd_pkg::ST_SHORT || r_status == cmd_pkg::ST_SIZE ||
                        r_status == cmd_pkg::ST_CONT || r_status == cmd_pkg::ST_NOPROG)
        |-> !r_msg_valid)
        else $error("error word carries a message byte");

    // any completion or error leaves the block idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept_in && n_status != cmd_pkg::ST_BUSY |=> r_phase == cmd_pkg::PH_IDLE)
        else $error("not idle after completion or error");

    // body phase only after the full three byte header
    a_body_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == cmd_pkg::PH_BODY |-> r_hdr_idx == 2'd3 && r_exp_total >= cmd_pkg::MIN_TOTAL)
        else $error("body phase without a complete header");
`endif

endmodule : chunked_message_deframer_unit

`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the chunked message deframer unit.
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned CYCLE_LIMIT   = 500000;
    localparam int unsigned LONGEST_TOTAL = 65538;

    // One result word as the block presents it
    typedef struct packed {
        cmd_pkg::t_status status;
        logic             last;
        logic             valid;
        logic [7:0]       data;
    } t_msg_word;

    logic i_clk;
    logic i_rst_n = 1'b0;

    logic                          i_cfg_we    = 1'b0;
    logic [cmd_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [cmd_pkg::CFG_W-1:0]     i_cfg_wdata = '0;

    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = '0;   // [7:0] rx_byte
    logic [1:0] s_axis_tuser  = '0;   // [0] operation, [1] chunk_start
    logic       s_axis_tlast  = 1'b0; // chunk_end

    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;         // [7:0] msg_byte
    logic [3:0] m_axis_tuser;         // [0] msg_byte_valid, [3:1] status
    logic       m_axis_tlast;         // msg_last

    chunked_message_deframer_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Mirror of the registers
    logic [cmd_pkg::LEN_W-1:0]  cfg_max_len  = cmd_pkg::RST_MAX_LEN;
    logic [cmd_pkg::IDLE_W-1:0] cfg_max_idle = cmd_pkg::RST_MAX_IDLE;
    logic [7:0]                 cfg_base     = cmd_pkg::RST_CSUM_BASE;
    logic [7:0]                 cfg_bypass   = cmd_pkg::RST_CSUM_BYP;

    // Mirror of the framing state
    cmd_pkg::t_phase           st_phase   = cmd_pkg::PH_IDLE;
    logic [1:0]                hdr_idx    = '0;
    logic [7:0]                cmd_byte   = '0;
    logic [cmd_pkg::LEN_W-1:0] total_len  = '0;
    logic [cmd_pkg::LEN_W-1:0] rx_count   = '0;
    logic [7:0]                sum_acc    = '0;
    logic [3:0]                empty_run  = '0;
    logic                      drop_chunk = 1'b0;
    logic                      mid_chunk  = 1'b0;

    t_msg_word   msg_words_due[$];
    int unsigned words_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches   = 0;
    int unsigned cycle_count  = 0;
    int unsigned snk_hold     = 0;
    bit          src_idle_on  = 1'b1;
    bit          snk_idle_on  = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    //------------------------------------------------------------------
    // Deframing predictor
    //------------------------------------------------------------------
    function automatic void return_to_idle(input bit drop);
        st_phase   = cmd_pkg::PH_IDLE;
        hdr_idx    = '0;
        cmd_byte   = '0;
        total_len  = '0;
        rx_count   = '0;
        sum_acc    = '0;
        empty_run  = '0;
        drop_chunk = drop;
    endfunction

    // Counts a chunk that added nothing; 1 when the no-progress limit is hit
    function automatic bit bump_empty_run();
        logic [4:0] next_run;
        next_run = {1'b0, empty_run} + 5'd1;
        if (next_run > {1'b0, cfg_max_idle})
            return 1'b1;
        empty_run = next_run[3:0];
        return 1'b0;
    endfunction

    function automatic t_msg_word deframe_step(input bit op, input logic [7:0] b,
                                               input bit eoc);
        t_msg_word                 r;
        bit                        first;
        logic [cmd_pkg::LEN_W-1:0] total;
        logic [7:0]                want;
        r = '{status: cmd_pkg::ST_BUSY, last: 1'b0, valid: 1'b0, data: 8'h00};
        if (op) begin
            if (bump_empty_run()) begin
                r.status = cmd_pkg::ST_NOPROG;
                return_to_idle(mid_chunk | drop_chunk);
            end
        end else begin
            first     = ~mid_chunk;
            mid_chunk = ~eoc;
            if (drop_chunk) begin
                if (eoc)
                    drop_chunk = 1'b0;
            end else if (st_phase == cmd_pkg::PH_IDLE) begin
                // command byte
                cmd_byte  = b;
                sum_acc   = b;
                rx_count  = 17'd1;
                hdr_idx   = 2'd1;
                empty_run = '0;
                st_phase  = cmd_pkg::PH_HEADER;
                if (eoc) begin
                    r.status = cmd_pkg::ST_SHORT;
                    return_to_idle(1'b0);
                end else begin
                    r.valid = 1'b1;
                end
            end else if (st_phase == cmd_pkg::PH_HEADER) begin
                if (hdr_idx == 2'd1) begin
                    // length, low byte
                    total_len = {9'd0, b};
                    sum_acc   = sum_acc + b;
                    rx_count  = 17'd2;
                    hdr_idx   = 2'd2;
                    if (eoc) begin
                        r.status = cmd_pkg::ST_SHORT;
                        return_to_idle(1'b0);
                    end else begin
                        r.valid = 1'b1;
                    end
                end else begin
                    // length, high byte: size check
                    total = cmd_pkg::HDR_BYTES + total_len + {1'b0, b, 8'h00};
                    if (total < cmd_pkg::MIN_TOTAL || total > cfg_max_len) begin
                        r.status = cmd_pkg::ST_SIZE;
                        return_to_idle(~eoc);
                    end else begin
                        total_len = total;
                        sum_acc   = sum_acc + b;
                        rx_count  = 17'd3;
                        hdr_idx   = 2'd3;
                        st_phase  = cmd_pkg::PH_BODY;
                        r.valid   = 1'b1;
                    end
                end
            end else if (first) begin
                // continuation byte, stripped
                if (!b[0] || {b[7:1], 1'b0} != cmd_byte) begin
                    r.status = cmd_pkg::ST_CONT;
                    return_to_idle(~eoc);
                end else if (eoc) begin
                    if (bump_empty_run()) begin
                        r.status = cmd_pkg::ST_NOPROG;
                        return_to_idle(1'b0);
                    end
                end
            end else begin
                rx_count  = rx_count + 17'd1;
                empty_run = '0;
                r.valid   = 1'b1;
                if (rx_count >= total_len) begin
                    want     = cfg_base - sum_acc;
                    r.last   = 1'b1;
                    r.status = (b == cfg_bypass || b == want) ? cmd_pkg::ST_GOOD
                                                               : cmd_pkg::ST_CSUM;
                    return_to_idle(~eoc);
                end else begin
                    sum_acc = sum_acc + b;
                end
            end
        end
        if (r.valid)
            r.data = b;
        return r;
    endfunction

    //------------------------------------------------------------------
    // Result side: random stalls and checking
    //------------------------------------------------------------------
    initial begin
        forever begin
            @(negedge i_clk);
            m_axis_tready <= (snk_hold == 0);
            if (snk_hold != 0)
                snk_hold--;
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready && snk_idle_on)
                snk_hold = $urandom_range(0, 3);
        end
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : check_msg_words
        t_msg_word got;
        t_msg_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.data   = m_axis_tdata;
            got.valid  = m_axis_tuser[0];
            got.last   = m_axis_tlast;
            got.status = cmd_pkg::t_status'(m_axis_tuser[3:1]);
            if (msg_words_due.size() == 0) begin
                report_mismatch($sformatf("result word %0d with nothing pending", results_seen));
            end else begin
                want = msg_words_due.pop_front();
                if (got !== want)
                    report_mismatch($sformatf({"word %0d: byte %02h valid %0d last %0d ",
                        "status %0d, want byte %02h valid %0d last %0d status %0d"},
                        results_seen, got.data, got.valid, got.last, got.status,
                        want.data, want.valid, want.last, want.status));
            end
            results_seen++;
        end
    end

    //------------------------------------------------------------------
    // Input side
    //------------------------------------------------------------------
    task automatic send_word(input bit op, input logic [7:0] b, input bit start, input bit eoc);
        int unsigned gap;
        gap = src_idle_on ? $urandom_range(0, 3) : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= {start, op};
        s_axis_tlast  <= eoc;
        do @(posedge i_clk); while (!s_axis_tready);
        msg_words_due.push_back(deframe_step(op, b, eoc));
        words_sent++;
    endtask

    // chunk_start is ignored by the block, so it is flipped now and then
    function automatic bit chunk_start_flag(input bit at_start);
        return at_start ^ ($urandom_range(0, 15) == 0);
    endfunction

    task automatic send_empty_chunk();
        send_word(1'b1, 8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic send_chunk(input logic [7:0] chunk_bytes[$]);
        foreach (chunk_bytes[i])
            send_word(1'b0, chunk_bytes[i], i == 0, i == chunk_bytes.size() - 1);
    endtask

    task automatic send_noise(input int unsigned n);
        repeat (n)
            send_word($urandom_range(0, 7) == 0, 8'($urandom),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // Lower valid, then wait for every pending word and let the block settle
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (msg_words_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Empty chunks until no-progress fires, then a chunk-ending byte: always idle after
    task automatic flush_to_idle();
        repeat (int'(cfg_max_idle) + 1)
            send_empty_chunk();
        send_word(1'b0, 8'($urandom), 1'b1, 1'b1);
    endtask

    task automatic write_reg(input logic [cmd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cmd_pkg::CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            cmd_pkg::CFG_MAX_LEN:   cfg_max_len  = value[cmd_pkg::LEN_W-1:0];
            cmd_pkg::CFG_MAX_IDLE:  cfg_max_idle = value[cmd_pkg::IDLE_W-1:0];
            cmd_pkg::CFG_CSUM_BASE: cfg_base     = value[7:0];
            cmd_pkg::CFG_CSUM_BYP:  cfg_bypass   = value[7:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [cmd_pkg::LEN_W-1:0] max_len,
                                  input logic [3:0] max_idle,
                                  input logic [7:0] base, input logic [7:0] bypass);
        write_reg(cmd_pkg::CFG_MAX_LEN, max_len);
        write_reg(cmd_pkg::CFG_MAX_IDLE, {13'd0, max_idle});
        write_reg(cmd_pkg::CFG_CSUM_BASE, {9'd0, base});
        write_reg(cmd_pkg::CFG_CSUM_BYP, {9'd0, bypass});
    endtask

    // One framed message split into chunks, mostly well formed with random content
    task automatic send_random_frame();
        logic [7:0]  cmd;
        logic [7:0]  cont;
        logic [7:0]  sum;
        logic [15:0] len;
        logic [7:0]  msg[$];
        int unsigned n;
        int unsigned pos;
        int unsigned junk;
        bit          first_chunk;
        bit          eoc;
        cmd = 8'($urandom);
        if ($urandom_range(0, 15) != 0)
            cmd[0] = 1'b0;
        case ($urandom_range(0, 9))
            6, 7: len = (cfg_max_len <= 100) ? 16'(cfg_max_len - 3 + $urandom_range(0, 1))
                                             : 16'($urandom_range(1, 12));
            8: len = 16'($urandom_range(256, 65535));
            9: len = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(13, 80));
            default: len = 16'($urandom_range(1, 12));
        endcase
        msg = '{cmd, len[7:0], len[15:8]};
        sum = cmd + len[7:0] + len[15:8];
        // long lengths stop after the header
        if (len != 0 && len <= 80) begin
            repeat (len - 1) begin
                msg.push_back(8'($urandom));
                sum = sum + msg[$];
            end
            case ($urandom_range(0, 9))
                6, 7:    msg.push_back(cfg_bypass);
                8, 9:    msg.push_back(8'($urandom));
                default: msg.push_back(cfg_base - sum);
            endcase
        end
        junk = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;

        pos = 0;
        first_chunk = 1'b1;
        while (pos < msg.size()) begin
            if (first_chunk) begin
                n = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
            end else begin
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(1, 2)) send_empty_chunk();
                n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
                cont = ($urandom_range(0, 24) == 0) ? 8'($urandom) : (cmd | 8'h01);
                send_word(1'b0, cont, chunk_start_flag(1'b1), n == 0);
            end
            if (n > msg.size() - pos)
                n = msg.size() - pos;
            for (int unsigned i = 0; i < n; i++) begin
                if (i != 0 && $urandom_range(0, 39) == 0)
                    send_empty_chunk();
                eoc = (i == n - 1) && !(pos == msg.size() - 1 && junk != 0);
                send_word(1'b0, msg[pos], chunk_start_flag(first_chunk && i == 0), eoc);
                pos++;
            end
            first_chunk = 1'b0;
        end
        // bytes past the end of the message, same chunk
        for (int unsigned k = 0; k < junk; k++)
            send_word(1'b0, 8'($urandom), chunk_start_flag(1'b0), k == junk - 1);
    endtask

    task automatic run_random_phase(input int unsigned n_words);
        int unsigned stop_at;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at) begin
            case ($urandom_range(0, 5))
                0: begin src_idle_on = 1'b0; snk_idle_on = 1'b0; end
                1: begin src_idle_on = 1'b0; snk_idle_on = 1'b1; end
                2: begin src_idle_on = 1'b1; snk_idle_on = 1'b0; end
                default: begin src_idle_on = 1'b1; snk_idle_on = 1'b1; end
            endcase
            if ($urandom_range(0, 6) == 0)
                send_noise($urandom_range(1, 6));
            else
                send_random_frame();
        end
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        flush_to_idle();
        drain_results();
    endtask

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------
    task automatic test_directed_frames();
        // good message over three chunks: single-byte continuation,
        // empty chunk in the middle of a chunk, computed checksum
        send_chunk('{8'h10, 8'h02, 8'h00});
        send_chunk('{8'h11});
        send_word(1'b0, 8'h11, 1'b1, 1'b0);
        send_empty_chunk();
        send_word(1'b0, 8'hFF, 1'b0, 1'b0);
        send_word(1'b0, 8'h99, 1'b0, 1'b1);
        // checksum mismatch, then the rest of the chunk is dropped
        send_chunk('{8'h20, 8'h01, 8'h00, 8'h00, 8'h5A});
        // short first chunk
        send_chunk('{8'hFF});
        // length zero is too short; rest of chunk dropped
        send_chunk('{8'h30, 8'h00, 8'h00, 8'h12});
        // largest length is over the reset limit
        send_chunk('{8'h30, 8'hFF, 8'hFF});
        // continuation without bit 0
        send_chunk('{8'h40, 8'h02, 8'h00});
        send_chunk('{8'h40});
        // command with bit 0 set can never be continued
        send_chunk('{8'h41, 8'h01, 8'h00});
        send_chunk('{8'h41, 8'h00});
    endtask

    task automatic test_random_default();
        run_random_phase(300);
    endtask

    task automatic test_register_extremes();
        drain_results();
        apply_settings(17'd4, 4'd0, 8'h00, 8'hFF);
        // no empty chunk tolerated while idle
        send_empty_chunk();
        // shortest message fits, one longer does not
        send_chunk('{8'h50, 8'h01, 8'h00, 8'hAF});
        send_chunk('{8'h50, 8'h02, 8'h00});
        drain_results();
    endtask

    task automatic test_random_settings();
        apply_settings(17'd4, 4'd0, 8'h00, 8'h00);
        run_random_phase(150);
        apply_settings(17'(LONGEST_TOTAL), 4'd15, 8'hFF, 8'hFF);
        run_random_phase(250);
        apply_settings(17'($urandom_range(20, 90)), 4'($urandom_range(1, 14)),
                       8'($urandom), 8'($urandom));
        run_random_phase(225);
        apply_settings(17'($urandom_range(4, LONGEST_TOTAL)), 4'($urandom_range(1, 14)),
                       8'($urandom), 8'($urandom));
        run_random_phase(225);
    endtask

    // Largest total length: accepted at the top limit and refused one below it
    task automatic test_longest_message();
        write_reg(cmd_pkg::CFG_MAX_LEN, 17'(LONGEST_TOTAL));
        // header of the largest message, a few body words, then abandoned
        send_chunk('{8'h5C, 8'hFF, 8'hFF, 8'h01, 8'h02});
        send_word(1'b0, 8'h5D, 1'b1, 1'b0);
        send_word(1'b0, 8'h03, 1'b0, 1'b1);
        flush_to_idle();
        drain_results();
        write_reg(cmd_pkg::CFG_MAX_LEN, 17'(LONGEST_TOTAL - 1));
        send_chunk('{8'h5C, 8'hFF, 8'hFF});
        drain_results();
    endtask

    //------------------------------------------------------------------
    // Sequence
    //------------------------------------------------------------------
    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_frames();
        test_random_default();
        test_register_extremes();
        test_random_settings();
        test_longest_message();
        drain_results();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

endmodule

// File: sim.f
hdl/cmd_pkg.sv
hdl/chunked_message_deframer_unit.sv
tb/testbench.sv
